// ===== rtl/lbf_pkg.sv =====
`default_nettype none

package lbf_pkg;

  // storage geometry
  localparam int MAX_ENTRIES = 8;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // word fields
  localparam int HANDLE_W = 16;
  localparam int SIZE_W   = 32;

  // configuration registers
  localparam int PDATA_W     = 32;
  localparam int PADDR_W     = 3;
  localparam int REG_SEL_BIT = 2;
  localparam int LIMIT_W     = 4;
  localparam int WASTE_W     = 9;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(2);
  localparam logic [WASTE_W-1:0] WASTE_RST = WASTE_W'(192);
  localparam logic [WASTE_W-1:0] WASTE_ONE = WASTE_W'(256);

  // limit compare width, one spare bit for count + 1
  localparam int LIM_W = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

  // fit arithmetic: floor(size * w / 256) split at the fraction point
  localparam int FRAC_W    = 8;
  localparam int MUL_HI_W  = SIZE_W - FRAC_W + WASTE_W;
  localparam int LO_PROD_W = FRAC_W + WASTE_W;
  localparam int LO_W      = WASTE_W;
  localparam int ALW_W     = SIZE_W + 2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic {
    REG_CACHE_LIMIT = 1'b0,
    REG_WASTE_Q8    = 1'b1
  } lbf_reg_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_PUSH,
    ST_DROP,
    ST_DROP_PUSH
  } lbf_st_op_t;

  typedef struct packed {
    lbf_st_op_t          op;
    logic [IDX_W-1:0]    idx;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } lbf_store_cmd_t;

  typedef struct packed {
    logic              valid;
    logic              fit;
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  idx;
  } lbf_fit_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FREE,
    S_FIN
  } lbf_state_t;

endpackage

`default_nettype wire

// ===== rtl/lbf_if.sv =====
`default_nettype none

interface lbf_in_if import lbf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [SIZE_W-1:0]   req_size;
  logic [HANDLE_W-1:0] handle;
  logic [SIZE_W-1:0]   freed_size;

  modport source (output valid, output kind, output req_size, output handle,
                  output freed_size, input ready);
  modport sink   (input valid, input kind, input req_size, input handle,
                  input freed_size, output ready);
endinterface

interface lbf_out_if import lbf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [HANDLE_W-1:0] reused_handle;
  logic                evict_valid;
  logic [HANDLE_W-1:0] evicted_handle;

  modport source (output valid, output hit, output reused_handle,
                  output evict_valid, output evicted_handle, input ready);
  modport sink   (input valid, input hit, input reused_handle,
                  input evict_valid, input evicted_handle, output ready);
endinterface

`default_nettype wire

// ===== rtl/lbf_store.sv =====
`default_nettype none

module lbf_store import lbf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  lbf_store_cmd_t      cmd,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic [HANDLE_W-1:0] rd_handle,
  output logic [SIZE_W-1:0]   rd_size,
  output logic [CNT_W-1:0]    count
);

  logic [HANDLE_W-1:0] hnd_r  [MAX_ENTRIES];
  logic [SIZE_W-1:0]   size_r [MAX_ENTRIES];
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [IDX_W-1:0]    drop_idx;

  // drop_push always drops the oldest slot
  assign drop_idx = (cmd.op == ST_DROP) ? cmd.idx : '0;

  always_ff @(posedge clk) begin
    case (cmd.op)
      ST_PUSH: begin
        hnd_r[cmd.idx]  <= cmd.handle;
        size_r[cmd.idx] <= cmd.size;
      end
      ST_DROP, ST_DROP_PUSH: begin
        for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
          // the slot that takes the new word is not shifted
          if (IDX_W'(i) >= drop_idx &&
              !(cmd.op == ST_DROP_PUSH && IDX_W'(i) == cmd.idx)) begin
            hnd_r[i]  <= hnd_r[i+1];
            size_r[i] <= size_r[i+1];
          end
        end
        if (cmd.op == ST_DROP_PUSH) begin
          hnd_r[cmd.idx]  <= cmd.handle;
          size_r[cmd.idx] <= cmd.size;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    case (cmd.op)
      ST_PUSH: count_nxt = count_r + CNT_W'(1);
      ST_DROP: count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign rd_handle = hnd_r[rd_idx];
  assign rd_size   = size_r[rd_idx];
  assign count     = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above storage depth");

  a_drop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ST_DROP) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("drop did not shrink the list");

endmodule

`default_nettype wire

// ===== rtl/lbf_fit_unit.sv =====
`default_nettype none

module lbf_fit_unit import lbf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               issue,
  input  logic [SIZE_W-1:0]  size,
  input  logic [IDX_W-1:0]   idx,
  input  logic [SIZE_W-1:0]  req,
  input  logic [WASTE_W-1:0] waste,
  output lbf_fit_res_t       res,
  output logic               busy
);

  // stage 1: partial products of size * waste
  logic                 v1_r;
  logic [SIZE_W-1:0]    s1_r;
  logic [IDX_W-1:0]     idx1_r;
  logic [MUL_HI_W-1:0]  hi_r;
  logic [MUL_HI_W-1:0]  hi_nxt;
  logic [LO_W-1:0]      lo_r;
  logic [LO_W-1:0]      lo_nxt;
  logic [LO_PROD_W-1:0] lo_prod;

  // stage 2: add, fit compare
  logic                 v2_r;
  logic                 fit_r;
  logic                 fit_nxt;
  logic [SIZE_W-1:0]    s2_r;
  logic [IDX_W-1:0]     idx2_r;
  logic [ALW_W-1:0]     allowed;

  assign hi_nxt  = MUL_HI_W'(size[SIZE_W-1:FRAC_W]) * MUL_HI_W'(waste);
  assign lo_prod = LO_PROD_W'(size[FRAC_W-1:0]) * LO_PROD_W'(waste);
  assign lo_nxt  = LO_W'(lo_prod[LO_PROD_W-1:FRAC_W]);

  assign allowed = ALW_W'(hi_r) + ALW_W'(lo_r);
  assign fit_nxt = (req <= s1_r) && (ALW_W'(s1_r - req) <= allowed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r   <= size;
    idx1_r <= idx;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    fit_r  <= fit_nxt;
    s2_r   <= s1_r;
    idx2_r <= idx1_r;
  end

  assign res.valid = v2_r;
  assign res.fit   = fit_r;
  assign res.size  = s2_r;
  assign res.idx   = idx2_r;
  assign busy      = v1_r | v2_r;

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("fit result without a product stage");

endmodule

`default_nettype wire

// ===== rtl/lru_best_fit_buffer_cache_core.sv =====
`default_nettype none
// best-fit cache of freed buffers, one word at a time through a shared fit unit
// allocate: the scan feeds one entry per cycle, newest to oldest, into the 2-stage fit pipe
//   over n = cached entries (1 to MAX_ENTRIES); an empty list goes straight to a miss
// free: a result shows in the cycle after the final state, which waits
//   while the previous result word is still held; reset (rst_n low, synchronous):
//   list empty, cache_limit 2, waste_q8 192, output empty; entries are not cleared

module lru_best_fit_buffer_cache_core import lbf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  lbf_in_if.sink             in_ch,
  lbf_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // configuration registers
  logic [LIMIT_W-1:0] limit_r;
  logic [WASTE_W-1:0] waste_r;
  logic [WASTE_W-1:0] waste_eff;
  lbf_reg_t           reg_sel;
  logic               cfg_wr;

  // sequencer
  lbf_state_t state_r, state_nxt;

  // latched input word
  logic                kind_r,    kind_nxt;
  logic [SIZE_W-1:0]   req_r,     req_nxt;
  logic [HANDLE_W-1:0] hin_r,     hin_nxt;
  logic [SIZE_W-1:0]   fsz_r,     fsz_nxt;

  // scan bookkeeping
  logic [IDX_W-1:0]    scan_idx_r,  scan_idx_nxt;
  logic                found_r,     found_nxt;
  logic [IDX_W-1:0]    best_idx_r,  best_idx_nxt;
  logic [SIZE_W-1:0]   best_size_r, best_size_nxt;

  // pending result and list update
  logic                res_hit_r, res_hit_nxt;
  logic [HANDLE_W-1:0] res_hnd_r, res_hnd_nxt;
  logic                res_ev_r,  res_ev_nxt;
  logic [HANDLE_W-1:0] res_evh_r, res_evh_nxt;
  lbf_st_op_t          op_r,      op_nxt;
  logic [IDX_W-1:0]    op_idx_r,  op_idx_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r,   out_hit_nxt;
  logic [HANDLE_W-1:0] out_hnd_r,   out_hnd_nxt;
  logic                out_ev_r,    out_ev_nxt;
  logic [HANDLE_W-1:0] out_evh_r,   out_evh_nxt;

  // store and fit unit hookup
  lbf_store_cmd_t      st_cmd;
  logic [IDX_W-1:0]    rd_idx;
  logic [HANDLE_W-1:0] rd_handle;
  logic [SIZE_W-1:0]   rd_size;
  logic [CNT_W-1:0]    count;
  logic                fit_issue;
  lbf_fit_res_t        fit_res;
  logic                fit_busy;

  // free path: does the list overflow the (clamped) limit
  logic [LIM_W-1:0]    cnt_plus;
  logic [LIM_W-1:0]    lim_eff;
  logic                overflow;

  lbf_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (st_cmd),
    .rd_idx    (rd_idx),
    .rd_handle (rd_handle),
    .rd_size   (rd_size),
    .count     (count)
  );

  lbf_fit_unit u_fit (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (fit_issue),
    .size  (rd_size),
    .idx   (scan_idx_r),
    .req   (req_r),
    .waste (waste_eff),
    .res   (fit_res),
    .busy  (fit_busy)
  );

  // ---------------------------------------------------------------------------
  // configuration port, always ready; low address bits are the byte offset
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = lbf_reg_t'(paddr[REG_SEL_BIT]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      waste_r <= WASTE_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_CACHE_LIMIT: limit_r <= pwdata[LIMIT_W-1:0];
        REG_WASTE_Q8:    waste_r <= pwdata[WASTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CACHE_LIMIT: prdata = PDATA_W'(limit_r);
      REG_WASTE_Q8:    prdata = PDATA_W'(waste_r);
      default:         prdata = '0;
    endcase
  end

  // waste above one whole buffer acts as one
  assign waste_eff = (waste_r > WASTE_ONE) ? WASTE_ONE : waste_r;

  // limit above storage acts as storage depth
  assign cnt_plus = LIM_W'(count) + LIM_W'(1);
  assign lim_eff  = (LIM_W'(limit_r) > LIM_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES)
                                                            : LIM_W'(limit_r);
  assign overflow = cnt_plus > lim_eff;

  // ---------------------------------------------------------------------------
  // sequencer
  // idle -> scan (newest to oldest) -> drain fit pipe -> fin   (allocate)
  // idle -> free -> fin                                         (free)
  // fin commits the list update and loads the output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    req_r       <= req_nxt;
    hin_r       <= hin_nxt;
    fsz_r       <= fsz_nxt;
    scan_idx_r  <= scan_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    res_hit_r   <= res_hit_nxt;
    res_hnd_r   <= res_hnd_nxt;
    res_ev_r    <= res_ev_nxt;
    res_evh_r   <= res_evh_nxt;
    op_r        <= op_nxt;
    op_idx_r    <= op_idx_nxt;
    out_hit_r   <= out_hit_nxt;
    out_hnd_r   <= out_hnd_nxt;
    out_ev_r    <= out_ev_nxt;
    out_evh_r   <= out_evh_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    req_nxt       = req_r;
    hin_nxt       = hin_r;
    fsz_nxt       = fsz_r;
    scan_idx_nxt  = scan_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_size_nxt = best_size_r;
    res_hit_nxt   = res_hit_r;
    res_hnd_nxt   = res_hnd_r;
    res_ev_nxt    = res_ev_r;
    res_evh_nxt   = res_evh_r;
    op_nxt        = op_r;
    op_idx_nxt    = op_idx_r;
    out_hit_nxt   = out_hit_r;
    out_hnd_nxt   = out_hnd_r;
    out_ev_nxt    = out_ev_r;
    out_evh_nxt   = out_evh_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    in_ch.ready   = 1'b0;
    fit_issue     = 1'b0;
    rd_idx        = scan_idx_r;
    st_cmd.op     = ST_NONE;
    st_cmd.idx    = op_idx_r;
    st_cmd.handle = hin_r;
    st_cmd.size   = fsz_r;

    // best-fit tracking: strict less keeps the newest on a tie
    if (fit_res.valid && fit_res.fit && (!found_r || fit_res.size < best_size_r)) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = fit_res.idx;
      best_size_nxt = fit_res.size;
    end

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          req_nxt   = in_ch.req_size;
          hin_nxt   = in_ch.handle;
          fsz_nxt   = in_ch.freed_size;
          found_nxt = 1'b0;
          if (in_ch.kind == KIND_FREE) begin
            state_nxt = S_FREE;
          end else if (count == '0) begin
            // empty list: straight to a miss
            state_nxt = S_DRAIN;
          end else begin
            scan_idx_nxt = IDX_W'(count - CNT_W'(1));
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // one entry per cycle into the fit unit
        fit_issue = 1'b1;
        rd_idx    = scan_idx_r;
        if (scan_idx_r == '0) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r - IDX_W'(1);
        end
      end

      S_DRAIN: begin
        rd_idx = best_idx_r;
        if (!fit_busy) begin
          res_hit_nxt = found_r;
          res_hnd_nxt = found_r ? rd_handle : '0;
          res_ev_nxt  = 1'b0;
          res_evh_nxt = '0;
          op_nxt      = found_r ? ST_DROP : ST_NONE;
          op_idx_nxt  = best_idx_r;
          state_nxt   = S_FIN;
        end
      end

      S_FREE: begin
        rd_idx      = '0;
        res_hit_nxt = 1'b0;
        res_hnd_nxt = '0;
        if (overflow) begin
          res_ev_nxt = 1'b1;
          if (count == '0) begin
            // limit of zero: the freed buffer goes straight back out
            res_evh_nxt = hin_r;
            op_nxt      = ST_NONE;
          end else begin
            res_evh_nxt = rd_handle;
            op_nxt      = ST_DROP_PUSH;
            op_idx_nxt  = IDX_W'(count - CNT_W'(1));
          end
        end else begin
          res_ev_nxt  = 1'b0;
          res_evh_nxt = '0;
          op_nxt      = ST_PUSH;
          op_idx_nxt  = IDX_W'(count);
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // wait for the output register to free up, then commit
        if (!out_valid_r || out_ch.ready) begin
          st_cmd.op     = op_r;
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_hnd_nxt   = res_hnd_r;
          out_ev_nxt    = res_ev_r;
          out_evh_nxt   = res_evh_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit            = out_hit_r;
  assign out_ch.reused_handle  = out_hnd_r;
  assign out_ch.evict_valid    = out_ev_r;
  assign out_ch.evicted_handle = out_evh_r;

  a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_ev_r))
    else $error("result word carries both a hit and an eviction");

  a_scan_feeds_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> fit_busy)
    else $error("scan cycle did not reach the fit unit");

endmodule

`default_nettype wire
